/* src/rgbpg_pkg.sv */
// Shared constants for the RGB to panel gray converter with rotation.
package rgbpg_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SRC_WIDTH     = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_PIXEL_LAYOUT  = 2'd2;
  localparam logic [1:0] REG_ROTATION_MODE = 2'd3;

  // Byte order codes.
  localparam logic LAYOUT_RGBA = 1'b0;
  localparam logic LAYOUT_BGRA = 1'b1;

  // Rotation codes; the unused code acts as no rotation.
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_CW   = 2'd1;
  localparam logic [1:0] ROT_CCW  = 2'd2;

  // Field and register widths.
  localparam int unsigned SIZE_REG_W = 12;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DEST_W     = 11;
  localparam int unsigned ADDR_W     = 22;

  // Luma weights, shift and quantization mask.
  localparam logic [6:0] COEF_R     = 7'd38;
  localparam logic [6:0] COEF_G     = 7'd75;
  localparam logic [6:0] COEF_B     = 7'd15;
  localparam int unsigned LUMA_SHIFT = 7;
  localparam logic [7:0] GRAY_MASK  = 8'hF0;

  // Reset value of the size registers.
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 12'd1;

endpackage

/* src/rgb_to_panel_gray_with_rotation.sv */
// RGB to 16-level panel gray converter with destination rotation.
// Each accepted pixel is held in the input register and then in the result register.
// Throughput: one pixel per cycle unless the output stalls; the luma and address math sit
// between an input register and a result register, and input stalls only once both hold a pixel.
// Reset: asynchronous, active low; clears the raster counters and valid flags
// and sets the size registers to 1, layout to RGBA and rotation to none.
module rgb_to_panel_gray_with_rotation #(
  parameter int unsigned MAX_DIM = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Pixel input.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [rgbpg_pkg::BYTE_W-1:0] byte0_i,
  input  logic [rgbpg_pkg::BYTE_W-1:0] byte1_i,
  input  logic [rgbpg_pkg::BYTE_W-1:0] byte2_i,
  // Result output.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  gray_level_o,
  output logic [rgbpg_pkg::DEST_W-1:0] dest_col_o,
  output logic [rgbpg_pkg::DEST_W-1:0] dest_row_o,
  output logic [rgbpg_pkg::ADDR_W-1:0] dest_addr_o,
  output logic        frame_end_o
);
  import rgbpg_pkg::*;

  // Counter width covers positions up to MAX_DIM-1; sizes need one bit more.
  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned SZ_W  = CW + 1;
  localparam int unsigned CMP_W = (SZ_W > SIZE_REG_W) ? SZ_W : SIZE_REG_W;
  localparam int unsigned OW    = (SZ_W > DEST_W) ? SZ_W : DEST_W;
  localparam int unsigned PW    = 2 * SZ_W + 1;
  localparam int unsigned AW    = (PW > ADDR_W) ? PW : ADDR_W;
  localparam logic [CMP_W-1:0] SIZE_CAP = CMP_W'(MAX_DIM);

  // Configuration registers.
  logic [SIZE_REG_W-1:0] src_width_q, src_height_q;
  logic                  pixel_layout_q;
  logic [1:0]            rotation_mode_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q     <= SIZE_RESET;
      src_height_q    <= SIZE_RESET;
      pixel_layout_q  <= LAYOUT_RGBA;
      rotation_mode_q <= ROT_NONE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SRC_WIDTH:     src_width_q     <= pwdata[SIZE_REG_W-1:0];
        REG_SRC_HEIGHT:    src_height_q    <= pwdata[SIZE_REG_W-1:0];
        REG_PIXEL_LAYOUT:  pixel_layout_q  <= pwdata[0];
        REG_ROTATION_MODE: rotation_mode_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      REG_SRC_WIDTH:     prdata = 32'(src_width_q);
      REG_SRC_HEIGHT:    prdata = 32'(src_height_q);
      REG_PIXEL_LAYOUT:  prdata = 32'(pixel_layout_q);
      REG_ROTATION_MODE: prdata = 32'(rotation_mode_q);
      default:           prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, large sizes saturate to MAX_DIM.
  logic [CMP_W-1:0] width_ext, height_ext;
  logic [SZ_W-1:0]  eff_w, eff_h;

  always_comb begin
    width_ext  = CMP_W'(src_width_q);
    height_ext = CMP_W'(src_height_q);
    if (width_ext == '0) begin
      eff_w = SZ_W'(1);
    end else if (width_ext > SIZE_CAP) begin
      eff_w = SZ_W'(MAX_DIM);
    end else begin
      eff_w = width_ext[SZ_W-1:0];
    end
    if (height_ext == '0) begin
      eff_h = SZ_W'(1);
    end else if (height_ext > SIZE_CAP) begin
      eff_h = SZ_W'(MAX_DIM);
    end else begin
      eff_h = height_ext[SZ_W-1:0];
    end
  end

  // Handshake control for the two register stages.
  logic s1_valid_q, out_valid_q;
  logic out_free, s1_adv, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Raster position of the next pixel, reset to zero if the size shrank.
  logic [CW-1:0] col_q, row_q;
  logic [SZ_W-1:0] pos_x, pos_y, next_x, next_y;
  logic at_last;

  always_comb begin
    pos_x = SZ_W'(col_q);
    pos_y = SZ_W'(row_q);
    if (pos_x >= eff_w) pos_x = '0;
    if (pos_y >= eff_h) pos_y = '0;
    at_last = (pos_x == eff_w - SZ_W'(1)) && (pos_y == eff_h - SZ_W'(1));
    next_x  = pos_x + SZ_W'(1);
    next_y  = pos_y;
    if (next_x >= eff_w) begin
      next_x = '0;
      next_y = pos_y + SZ_W'(1);
      if (next_y >= eff_h) next_y = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= next_x[CW-1:0];
      row_q <= next_y[CW-1:0];
    end
  end

  // Input register: color channels in R, G, B order and the source position.
  logic [BYTE_W-1:0] red_q, green_q, blue_q;
  logic [CW-1:0]     x_q, y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      red_q   <= (pixel_layout_q == LAYOUT_BGRA) ? byte2_i : byte0_i;
      green_q <= byte1_i;
      blue_q  <= (pixel_layout_q == LAYOUT_BGRA) ? byte0_i : byte2_i;
      x_q     <= pos_x[CW-1:0];
      y_q     <= pos_y[CW-1:0];
    end
  end

  // Luma from fixed weights, keeping the upper nibble only.
  logic [14:0] luma_sum;
  logic [7:0]  gray_d;

  assign luma_sum = 15'(COEF_R) * 15'(red_q) + 15'(COEF_G) * 15'(green_q)
                  + 15'(COEF_B) * 15'(blue_q);
  assign gray_d   = luma_sum[LUMA_SHIFT +: 8] & GRAY_MASK;

  // Destination position and linear address for the selected rotation.
  logic [SZ_W-1:0] sx, sy, dx, dy, out_w;
  logic [AW-1:0]   addr_d;
  logic [OW-1:0]   dx_ext, dy_ext;
  logic            last_d;

  always_comb begin
    sx = SZ_W'(x_q);
    sy = SZ_W'(y_q);
    case (rotation_mode_q)
      ROT_CW: begin
        dx    = eff_h - SZ_W'(1) - sy;
        dy    = sx;
        out_w = eff_h;
      end
      ROT_CCW: begin
        dx    = sy;
        dy    = eff_w - SZ_W'(1) - sx;
        out_w = eff_h;
      end
      default: begin
        dx    = sx;
        dy    = sy;
        out_w = eff_w;
      end
    endcase
    addr_d = AW'(dy) * AW'(out_w) + AW'(dx);
    dx_ext = OW'(dx);
    dy_ext = OW'(dy);
    last_d = (sx == eff_w - SZ_W'(1)) && (sy == eff_h - SZ_W'(1));
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      gray_level_o <= gray_d;
      dest_col_o   <= dx_ext[DEST_W-1:0];
      dest_row_o   <= dy_ext[DEST_W-1:0];
      dest_addr_o  <= addr_d[ADDR_W-1:0];
      frame_end_o  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // An accepted request always lands in the input register.
  a_fire_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted pixel did not reach the input register");

  // A stalled input stage keeps its pixel and position.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(x_q) && $stable(y_q))
    else $error("stalled input stage lost its pixel");

  // The raster counters wrap to the origin after the last pixel of a frame.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && at_last |=> col_q == '0 && row_q == '0)
    else $error("raster counters did not wrap at frame end");

  // The quantized level never carries low bits.
  a_gray_quant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gray_level_o[3:0] == 4'd0)
    else $error("gray level has low bits set");
`endif

endmodule
